FILE: rtl/core/bounded_morton_code_3d_unit_defines.svh
// assertion macros for the bounded morton code unit checker
// expects clk and rst_n in the scope where a macro is used
`ifndef BOUNDED_MORTON_CODE_3D_UNIT_DEFINES_SVH
`define BOUNDED_MORTON_CODE_3D_UNIT_DEFINES_SVH

// checked only while out of reset
`define BMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define BMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/core/bmc_pkg.sv
// shared types and constants of the bounded morton code unit
// no dependencies
`timescale 1ns / 1ps

package bmc_pkg;

  localparam int COORD_W     = 32;
  localparam int INDEX_W     = 16;
  localparam int MORTON_W    = 63;
  localparam int QUEUE_DEPTH = 2;

  // how one axis of an encode request is finished
  typedef enum logic [1:0] {
    Q_ZERO = 2'b00,
    Q_TOP  = 2'b01,
    Q_DIV  = 2'b10
  } qsel_t;

  typedef struct packed {
    qsel_t               sel;
    logic [COORD_W-1:0]  diff;
    logic [COORD_W-1:0]  span;
  } axis_job_t;

  typedef struct packed {
    axis_job_t           x;
    axis_job_t           y;
    axis_job_t           z;
    logic [INDEX_W-1:0]  index;
  } enc_job_t;

  typedef struct packed {
    logic      push;
    enc_job_t  job;
  } enc_push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  function automatic axis_job_t classify(input logic signed [COORD_W-1:0] p,
                                         input logic signed [COORD_W-1:0] lo,
                                         input logic signed [COORD_W-1:0] hi);
    axis_job_t          a;
    logic [COORD_W:0]   span_w;
    logic [COORD_W:0]   diff_w;
    span_w = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
    diff_w = {p[COORD_W-1], p} - {lo[COORD_W-1], lo};
    a.span = span_w[COORD_W-1:0];
    a.diff = diff_w[COORD_W-1:0];
    if (hi <= lo || p <= lo) begin
      a.sel = Q_ZERO;
    end else if (p >= hi) begin
      a.sel = Q_TOP;
    end else begin
      a.sel = Q_DIV;
    end
    return a;
  endfunction

endpackage

FILE: rtl/core/bmc_if.sv
// request and result channel interfaces of the bounded morton code unit
// depends on bmc_pkg
`timescale 1ns / 1ps

interface bmc_in_if import bmc_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       mode;
  logic                       first;
  logic signed [COORD_W-1:0]  x_coord;
  logic signed [COORD_W-1:0]  y_coord;
  logic signed [COORD_W-1:0]  z_coord;
  logic [INDEX_W-1:0]         point_index;

  modport source (output valid, mode, first, x_coord, y_coord, z_coord, point_index,
                  input ready);
  modport sink (input valid, mode, first, x_coord, y_coord, z_coord, point_index,
                output ready);
endinterface

interface bmc_out_if import bmc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [MORTON_W-1:0]    morton_value;
  logic [INDEX_W-1:0]     index_out;

  modport source (output valid, morton_value, index_out, input ready);
  modport sink (input valid, morton_value, index_out, output ready);
endinterface

FILE: rtl/core/bounded_morton_code_3d_unit.sv
// channel   | dir | payload
// in_ch     | in  | mode, first, x_coord, y_coord, z_coord, point_index
// out_ch    | out | morton_value, index_out
//
// a bounds request needs only a free queue slot
// an encode request passes through the queue, the three bit-serial dividers
// and the result register; the back end starts the next encode only once
// that result is loaded, and the dividers make one quotient bit per cycle
// a two-deep queue lets the front keep taking requests while the back divides
// reset is synchronous, active low, and clears bounds, queue and result valid
// a stalled result holds in the output register; the back waits, then the queue fills
`timescale 1ns / 1ps

module bounded_morton_code_3d_unit import bmc_pkg::*; #(
  parameter int AXIS_BITS = 21
) (
  input  logic        clk,
  input  logic        rst_n,
  bmc_in_if.sink      in_ch,
  bmc_out_if.source   out_ch
);

  enc_push_t    q_wr;
  enc_job_t     q_job;
  queue_stat_t  q_stat;
  logic         q_pop;

  bmc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_wr   (q_wr)
  );

  bmc_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_wr),
    .pop    (q_pop),
    .rd_job (q_job),
    .stat   (q_stat)
  );

  bmc_back #(
    .AXIS_BITS (AXIS_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .job_in (q_job),
    .q_stat (q_stat),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

endmodule

FILE: rtl/core/bmc_queue.sv
// short queue of classified encode requests between front and back
// depends on bmc_pkg
`timescale 1ns / 1ps

module bmc_queue import bmc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  enc_push_t    wr,
  input  logic         pop,
  output enc_job_t     rd_job,
  output queue_stat_t  stat
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  enc_job_t           mem_r [QUEUE_DEPTH];
  logic [PtrW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (cnt_r == CntW'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = wr.push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_job     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr.job;
    end
  end

endmodule

FILE: rtl/core/bmc_front.sv
// front end: takes requests, keeps the per-axis bounds, classifies encodes
// depends on bmc_pkg and bmc_if
`timescale 1ns / 1ps

module bmc_front import bmc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  bmc_in_if.sink       in_ch,
  input  queue_stat_t  q_stat,
  output enc_push_t    q_wr
);

  logic signed [COORD_W-1:0]  lo_x_r, lo_y_r, lo_z_r;
  logic signed [COORD_W-1:0]  hi_x_r, hi_y_r, hi_z_r;
  logic signed [COORD_W-1:0]  lo_x_nxt, lo_y_nxt, lo_z_nxt;
  logic signed [COORD_W-1:0]  hi_x_nxt, hi_y_nxt, hi_z_nxt;
  logic                       bounds_valid_r, bounds_valid_nxt;
  logic                       accept;
  enc_job_t                   job;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    job.x     = classify(in_ch.x_coord, lo_x_r, hi_x_r);
    job.y     = classify(in_ch.y_coord, lo_y_r, hi_y_r);
    job.z     = classify(in_ch.z_coord, lo_z_r, hi_z_r);
    job.index = in_ch.point_index;
    // no bounds yet: code is zero
    if (!bounds_valid_r) begin
      job.x.sel = Q_ZERO;
      job.y.sel = Q_ZERO;
      job.z.sel = Q_ZERO;
    end
    q_wr.job  = job;
    q_wr.push = accept && in_ch.mode;
  end

  always_comb begin
    lo_x_nxt         = lo_x_r;
    lo_y_nxt         = lo_y_r;
    lo_z_nxt         = lo_z_r;
    hi_x_nxt         = hi_x_r;
    hi_y_nxt         = hi_y_r;
    hi_z_nxt         = hi_z_r;
    bounds_valid_nxt = bounds_valid_r;
    if (accept && !in_ch.mode) begin
      bounds_valid_nxt = 1'b1;
      if (in_ch.first || !bounds_valid_r) begin
        lo_x_nxt = in_ch.x_coord;
        lo_y_nxt = in_ch.y_coord;
        lo_z_nxt = in_ch.z_coord;
        hi_x_nxt = in_ch.x_coord;
        hi_y_nxt = in_ch.y_coord;
        hi_z_nxt = in_ch.z_coord;
      end else begin
        if (in_ch.x_coord < lo_x_r) lo_x_nxt = in_ch.x_coord;
        if (in_ch.y_coord < lo_y_r) lo_y_nxt = in_ch.y_coord;
        if (in_ch.z_coord < lo_z_r) lo_z_nxt = in_ch.z_coord;
        if (in_ch.x_coord > hi_x_r) hi_x_nxt = in_ch.x_coord;
        if (in_ch.y_coord > hi_y_r) hi_y_nxt = in_ch.y_coord;
        if (in_ch.z_coord > hi_z_r) hi_z_nxt = in_ch.z_coord;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_x_r         <= '0;
      lo_y_r         <= '0;
      lo_z_r         <= '0;
      hi_x_r         <= '0;
      hi_y_r         <= '0;
      hi_z_r         <= '0;
      bounds_valid_r <= 1'b0;
    end else begin
      lo_x_r         <= lo_x_nxt;
      lo_y_r         <= lo_y_nxt;
      lo_z_r         <= lo_z_nxt;
      hi_x_r         <= hi_x_nxt;
      hi_y_r         <= hi_y_nxt;
      hi_z_r         <= hi_z_nxt;
      bounds_valid_r <= bounds_valid_nxt;
    end
  end

endmodule

FILE: rtl/core/bmc_back.sv
// back end: bit-serial dividers for the three axes, interleave, result register
// depends on bmc_pkg and bmc_if
`timescale 1ns / 1ps

module bmc_back import bmc_pkg::*; #(
  parameter int AXIS_BITS = 21
) (
  input  logic         clk,
  input  logic         rst_n,
  input  enc_job_t     job_in,
  input  queue_stat_t  q_stat,
  output logic         pop,
  bmc_out_if.source    out_ch
);

  localparam int CntW = (AXIS_BITS > 1) ? $clog2(AXIS_BITS) : 1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CntW-1:0]        cnt_r, cnt_nxt;
  qsel_t                  sel_r [3];
  logic [COORD_W-1:0]     span_r [3];
  logic [COORD_W-1:0]     rem_r [3];
  logic [COORD_W-1:0]     rem_nxt [3];
  logic [AXIS_BITS-1:0]   quo_r [3];
  logic [AXIS_BITS-1:0]   quo_nxt [3];
  logic [AXIS_BITS-1:0]   qval [3];
  logic [INDEX_W-1:0]     index_r;
  axis_job_t              job_axes [3];
  logic [MORTON_W-1:0]    code;
  logic                   out_valid_r, out_valid_nxt;
  logic [MORTON_W-1:0]    out_code_r;
  logic [INDEX_W-1:0]     out_index_r;
  logic                   load_out;

  assign job_axes[0] = job_in.x;
  assign job_axes[1] = job_in.y;
  assign job_axes[2] = job_in.z;

  // one restoring step per axis
  always_comb begin
    logic [COORD_W:0] r2;
    logic             ge;
    for (int a = 0; a < 3; a++) begin
      r2 = {rem_r[a], 1'b0};
      ge = (r2 >= {1'b0, span_r[a]});
      rem_nxt[a] = ge ? COORD_W'(r2 - {1'b0, span_r[a]}) : r2[COORD_W-1:0];
      quo_nxt[a] = AXIS_BITS'({quo_r[a], ge});
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      case (sel_r[a])
        Q_ZERO:  qval[a] = '0;
        Q_TOP:   qval[a] = '1;
        Q_DIV:   qval[a] = quo_r[a];
        default: qval[a] = '0;
      endcase
    end
    code = '0;
    for (int b = 0; b < AXIS_BITS; b++) begin
      code[3*b]     = qval[0][b];
      code[3*b + 1] = qval[1][b];
      code[3*b + 2] = qval[2][b];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pop           = 1'b0;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (!q_stat.empty) begin
          pop       = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (cnt_r == CntW'(AXIS_BITS - 1)) begin
          state_nxt = S_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      for (int a = 0; a < 3; a++) begin
        sel_r[a]  <= job_axes[a].sel;
        span_r[a] <= job_axes[a].span;
        rem_r[a]  <= job_axes[a].diff;
        quo_r[a]  <= '0;
      end
      index_r <= job_in.index;
    end else if (state_r == S_DIV) begin
      for (int a = 0; a < 3; a++) begin
        rem_r[a] <= rem_nxt[a];
        quo_r[a] <= quo_nxt[a];
      end
    end
    if (load_out) begin
      out_code_r  <= code;
      out_index_r <= index_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.morton_value = out_code_r;
  assign out_ch.index_out    = out_index_r;

endmodule

FILE: rtl/core/bmc_checker.sv
// port-level checker for the bounded morton code unit, bound to the top level
// depends on bmc_pkg and bounded_morton_code_3d_unit_defines.svh
`timescale 1ns / 1ps
`include "bounded_morton_code_3d_unit_defines.svh"

module bmc_checker import bmc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [MORTON_W-1:0]  out_morton,
  input logic [INDEX_W-1:0]   out_index
);

  `BMC_ASSERT(a_out_valid_holds, out_valid && !out_ready |=> out_valid, "result dropped while stalled")
  `BMC_ASSERT(a_out_data_holds, out_valid && !out_ready |=> $stable(out_morton) && $stable(out_index), "result changed while stalled")
  `BMC_ASSERT_ALWAYS(a_rst_no_result, !rst_n |=> !out_valid, "result valid after reset")
  `BMC_ASSERT_ALWAYS(a_rst_ready, !rst_n |=> in_ready, "not ready after reset")

endmodule

bind bounded_morton_code_3d_unit bmc_checker u_bmc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_morton (out_ch.morton_value),
  .out_index  (out_ch.index_out)
);

FILE: sim/bmc_morton_checker.sv
// result checker for the bounded morton code unit: watches both channels,
// keeps its own copy of the bounds box and predicts each code and index
// depends on bmc_pkg and the channel interfaces in bmc_if
`timescale 1ns / 1ps

module bmc_morton_checker import bmc_pkg::*; #(
  parameter int AXIS_BITS = 21
) (
  input  logic  clk,
  input  logic  rst_n,
  bmc_in_if     in_mon,
  bmc_out_if    out_mon,
  output int    fail_count,
  output int    codes_pending,
  output int    codes_checked
);

  localparam logic MODE_BOUNDS = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  typedef struct packed {
    logic [MORTON_W-1:0] code;
    logic [INDEX_W-1:0]  index;
  } coded_point_t;

  coded_point_t               expected_codes[$];
  logic signed [COORD_W-1:0]  box_lo[3];
  logic signed [COORD_W-1:0]  box_hi[3];
  logic                       box_valid;

  function automatic logic [AXIS_BITS-1:0] quantize_axis(input logic signed [COORD_W-1:0] p,
                                                        input logic signed [COORD_W-1:0] lo,
                                                        input logic signed [COORD_W-1:0] hi);
    logic [63:0] span;
    logic [63:0] offset;
    logic [63:0] q;
    logic [63:0] top;
    top = (64'd1 << AXIS_BITS) - 64'd1;
    if (hi <= lo || p <= lo) return '0;
    if (p >= hi) return top[AXIS_BITS-1:0];
    span   = 64'(longint'(hi) - longint'(lo));
    offset = 64'(longint'(p) - longint'(lo));
    q = (offset << AXIS_BITS) / span;
    if (q > top) q = top;
    return q[AXIS_BITS-1:0];
  endfunction

  // x in bit 0, y in bit 1, z in bit 2 of every triple
  function automatic logic [MORTON_W-1:0] interleave_axes(input logic [AXIS_BITS-1:0] qx,
                                                          input logic [AXIS_BITS-1:0] qy,
                                                          input logic [AXIS_BITS-1:0] qz);
    logic [MORTON_W-1:0] code;
    code = '0;
    for (int i = 0; i < AXIS_BITS; i++) begin
      code[3*i]     = qx[i];
      code[3*i + 1] = qy[i];
      code[3*i + 2] = qz[i];
    end
    return code;
  endfunction

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] want);
    $display("%0d ns: mismatch on %s, got %h, want %h", $time, what, got, want);
    fail_count++;
  endtask

  task automatic track_request(input logic mode, input logic first,
                               input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y,
                               input logic signed [COORD_W-1:0] z,
                               input logic [INDEX_W-1:0] idx);
    logic signed [COORD_W-1:0] p[3];
    logic [AXIS_BITS-1:0]      q[3];
    coded_point_t              c;
    p = '{x, y, z};
    if (mode == MODE_BOUNDS) begin
      for (int a = 0; a < 3; a++) begin
        if (first || !box_valid) begin
          box_lo[a] = p[a];
          box_hi[a] = p[a];
        end else begin
          if (p[a] < box_lo[a]) box_lo[a] = p[a];
          if (p[a] > box_hi[a]) box_hi[a] = p[a];
        end
      end
      box_valid = 1'b1;
    end else if (mode == MODE_ENCODE) begin
      c.code  = '0;
      c.index = idx;
      if (box_valid) begin
        for (int a = 0; a < 3; a++) q[a] = quantize_axis(p[a], box_lo[a], box_hi[a]);
        c.code = interleave_axes(q[0], q[1], q[2]);
      end
      expected_codes.push_back(c);
    end
  endtask

  task automatic compare_code(input logic [MORTON_W-1:0] code, input logic [INDEX_W-1:0] idx);
    coded_point_t want;
    if (expected_codes.size() == 0) begin
      flag_mismatch("result with no request waiting", 64'(code), 64'd0);
    end else begin
      want = expected_codes.pop_front();
      codes_checked++;
      if (code !== want.code) flag_mismatch("morton_value", 64'(code), 64'(want.code));
      if (idx !== want.index) flag_mismatch("index_out", 64'(idx), 64'(want.index));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      expected_codes.delete();
      for (int a = 0; a < 3; a++) begin
        box_lo[a] = '0;
        box_hi[a] = '0;
      end
      box_valid     = 1'b0;
      fail_count    = 0;
      codes_checked = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) compare_code(out_mon.morton_value, out_mon.index_out);
      if (in_mon.valid && in_mon.ready) begin
        track_request(in_mon.mode, in_mon.first, in_mon.x_coord, in_mon.y_coord,
                      in_mon.z_coord, in_mon.point_index);
      end
    end
    codes_pending = expected_codes.size();
  end

endmodule

FILE: sim/bounded_morton_code_3d_unit_tb.sv
// top of the bounded morton code unit testbench: clock, reset, request and
// result traffic with random gaps and stalls, watchdog and verdict
// depends on bmc_pkg, bmc_if, the unit itself and bmc_morton_checker
`timescale 1ns / 1ps

module bounded_morton_code_3d_unit_tb;
  import bmc_pkg::*;

  localparam int AXIS_BITS    = 21;
  localparam int RANDOM_ITEMS = 750;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = AXIS_BITS + 10;
  localparam int ONE          = 1 << 16;

  localparam logic MODE_BOUNDS = 1'b0;
  localparam logic MODE_ENCODE = 1'b1;

  localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7fff_ffff;

  logic clk;
  logic rst_n;

  bmc_in_if  in_ch ();
  bmc_out_if out_ch ();

  int fail_count;
  int codes_pending;
  int codes_checked;
  int bounds_sent;
  int encodes_sent;
  int random_sent;
  int point_sets;
  int drains;
  bit tx_calm;
  bit rx_calm;

  longint seen_lo[3];
  longint seen_hi[3];

  bounded_morton_code_3d_unit #(.AXIS_BITS(AXIS_BITS)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  bmc_morton_checker #(.AXIS_BITS(AXIS_BITS)) morton_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .codes_pending (codes_pending),
    .codes_checked (codes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [COORD_W-1:0] sat_coord(input longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return v[COORD_W-1:0];
  endfunction

  function automatic longint spread_offset(input longint r);
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return longint'(raw % 64'(2 * r + 1)) - r;
  endfunction

  task automatic send_request(input logic mode, input logic first,
                              input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y,
                              input logic signed [COORD_W-1:0] z,
                              input logic [INDEX_W-1:0] idx);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode        <= mode;
    in_ch.first       <= first;
    in_ch.x_coord     <= x;
    in_ch.y_coord     <= y;
    in_ch.z_coord     <= z;
    in_ch.point_index <= idx;
    in_ch.valid       <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    if (mode == MODE_BOUNDS) bounds_sent++;
    else encodes_sent++;
  endtask

  // hold requests back until every code in flight has come out
  task automatic drain_codes();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (codes_pending != 0) @(negedge clk);
    drains++;
  endtask

  task automatic run_directed();
    // encode with no bounds yet
    send_request(MODE_ENCODE, 1'b1, COORD_MAX, COORD_MIN, -32'sd1, 16'hffff);
    send_request(MODE_ENCODE, 1'b0, 32'sd0, 32'sd0, 32'sd0, 16'h0000);
    // bounds point without first while no bounds exist
    send_request(MODE_BOUNDS, 1'b0, -100 * ONE, -50 * ONE, 32'sd0, 16'hffff);
    send_request(MODE_BOUNDS, 1'b0, 100 * ONE, 50 * ONE, 32'sd1, 16'h0000);
    send_request(MODE_BOUNDS, 1'b0, 32'sd0, 32'sd0, 32'sd0, 16'h5a5a);
    // at, below, at and above the box edges, then inside
    send_request(MODE_ENCODE, 1'b0, -100 * ONE, -50 * ONE, 32'sd0, 16'h0001);
    send_request(MODE_ENCODE, 1'b1, -101 * ONE, COORD_MIN, -32'sd1, 16'h8000);
    send_request(MODE_ENCODE, 1'b0, 100 * ONE, 50 * ONE, 32'sd1, 16'h7fff);
    send_request(MODE_ENCODE, 1'b0, COORD_MAX, 51 * ONE, 32'sd2, 16'haaaa);
    send_request(MODE_ENCODE, 1'b0, 32'sd0, 25 * ONE, 32'sd0, 16'h5555);
    send_request(MODE_ENCODE, 1'b0, 100 * ONE - 1, 50 * ONE - 1, 32'sd1, 16'h1234);
    // widest possible box
    send_request(MODE_BOUNDS, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN, 16'h0000);
    send_request(MODE_BOUNDS, 1'b0, COORD_MAX, COORD_MAX, COORD_MAX, 16'hffff);
    send_request(MODE_ENCODE, 1'b0, 32'sd0, -32'sd1, 32'sd1, 16'hfffe);
    send_request(MODE_ENCODE, 1'b0, COORD_MIN + 1, COORD_MAX - 1, 32'sh5555_5555, 16'h0002);
    send_request(MODE_ENCODE, 1'b0, 32'shaaaa_aaaa, 32'sh1234_5678, -32'sh1234_5678,
                 16'hc3c3);
    // single point box, every axis degenerate
    send_request(MODE_BOUNDS, 1'b1, 5 * ONE, 5 * ONE, 5 * ONE, 16'h3c3c);
    send_request(MODE_ENCODE, 1'b0, 5 * ONE, 5 * ONE, 5 * ONE, 16'h0f0f);
    send_request(MODE_ENCODE, 1'b0, 6 * ONE, 4 * ONE, COORD_MAX, 16'hf0f0);
    // only x has extent
    send_request(MODE_BOUNDS, 1'b1, 32'sd0, -32'sd1, 32'sd7, 16'h0100);
    send_request(MODE_BOUNDS, 1'b0, 32'sd10, -32'sd1, 32'sd7, 16'h0200);
    send_request(MODE_ENCODE, 1'b0, 32'sd3, -32'sd1, 32'sd7, 16'h0300);
    send_request(MODE_ENCODE, 1'b1, 32'sd9, COORD_MAX, COORD_MIN, 16'h0400);
  endtask

  task automatic run_point_set();
    longint                    center[3];
    longint                    radius[3];
    logic signed [COORD_W-1:0] pt[3];
    int                        n_bounds;
    int                        n_encode;
    int                        sel;
    logic                      first;
    tx_calm = ($urandom_range(0, 4) == 0);
    for (int a = 0; a < 3; a++) begin
      sel = $urandom_range(0, 9);
      center[a] = longint'($signed($urandom()));
      if (sel == 0) radius[a] = 0;
      else if (sel <= 3) radius[a] = $urandom_range(1, 255);
      else if (sel <= 6) radius[a] = $urandom_range(256, 1 << 20);
      else radius[a] = $urandom_range(1 << 20, 32'h7fff_ffff);
    end
    // now and then an encode pass reuses the previous box
    n_bounds = ($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 8);
    n_encode = $urandom_range(4, 30);
    for (int j = 0; j < n_bounds; j++) begin
      if (j == 0) first = ($urandom_range(0, 7) != 0);
      else first = ($urandom_range(0, 9) == 0);
      for (int a = 0; a < 3; a++) begin
        pt[a] = sat_coord(center[a] + spread_offset(radius[a]));
        if (j == 0 || first) begin
          seen_lo[a] = pt[a];
          seen_hi[a] = pt[a];
        end else begin
          if (pt[a] < seen_lo[a]) seen_lo[a] = pt[a];
          if (pt[a] > seen_hi[a]) seen_hi[a] = pt[a];
        end
      end
      send_request(MODE_BOUNDS, first, pt[0], pt[1], pt[2], 16'($urandom()));
      random_sent++;
    end
    for (int j = 0; j < n_encode; j++) begin
      for (int a = 0; a < 3; a++) begin
        sel = $urandom_range(0, 9);
        case (sel)
          6: pt[a] = sat_coord(seen_lo[a]);
          7: pt[a] = sat_coord(seen_hi[a]);
          8: pt[a] = sat_coord(($urandom_range(0, 1) ? seen_hi[a] : seen_lo[a]) +
                               longint'($urandom_range(0, 2)) - 1);
          9: pt[a] = $signed($urandom());
          default: pt[a] = sat_coord(center[a] + spread_offset(radius[a] + radius[a] / 4 + 2));
        endcase
      end
      send_request(MODE_ENCODE, 1'($urandom()), pt[0], pt[1], pt[2], 16'($urandom()));
      random_sent++;
    end
    point_sets++;
  endtask

  // result side: random stall before each result, with calm stretches
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = rx_calm ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
      if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog: no request or result moved for %0d cycles", IDLE_LIMIT);
    $display("bounded_morton_code_3d_unit_tb: FAIL");
    $finish;
  end

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.mode        = MODE_BOUNDS;
    in_ch.first       = 1'b0;
    in_ch.x_coord     = '0;
    in_ch.y_coord     = '0;
    in_ch.z_coord     = '0;
    in_ch.point_index = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    run_directed();
    drain_codes();
    while (random_sent < RANDOM_ITEMS) begin
      run_point_set();
      if (point_sets == 3 || $urandom_range(0, 7) == 0) drain_codes();
    end
    in_ch.valid <= 1'b0;
    while (codes_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("sent %0d bounds and %0d encode requests over %0d random point sets",
             bounds_sent, encodes_sent, point_sets);
    $display("%0d codes checked, sender held until empty %0d times", codes_checked, drains);
    if (fail_count == 0 && codes_pending == 0) begin
      $display("bounded_morton_code_3d_unit_tb: PASS");
    end else begin
      $display("bounded_morton_code_3d_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/bmc_pkg.sv
rtl/core/bmc_if.sv
rtl/core/bmc_queue.sv
rtl/core/bmc_front.sv
rtl/core/bmc_back.sv
rtl/core/bounded_morton_code_3d_unit.sv
rtl/core/bmc_checker.sv
sim/bmc_morton_checker.sv
sim/bounded_morton_code_3d_unit_tb.sv
